// File: sv/rlec_pkg.sv
package rlec_pkg;

    localparam logic KIND_ACQUIRE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [2:0] STS_HIT       = 3'd0;
    localparam logic [2:0] STS_LOADED    = 3'd1;
    localparam logic [2:0] STS_FULL      = 3'd2;
    localparam logic [2:0] STS_NOT_FOUND = 3'd3;
    localparam logic [2:0] STS_BAD_COUNT = 3'd4;
    localparam logic [2:0] STS_OVERFLOW  = 3'd5;

    typedef enum logic [3:0] {
        OP_OVERFLOW,
        OP_HIT,
        OP_HIT_UNUSED,
        OP_LOAD,
        OP_FULL,
        OP_NOT_FOUND,
        OP_BAD_COUNT,
        OP_REL_KEEP,
        OP_REL_HEAD,
        OP_REL_TAIL
    } t_op;

    typedef struct packed {
        logic        valid;
        logic [7:0]  refs;
        logic [31:0] device;
        logic [31:0] key;
    } t_entry;

    typedef struct packed {
        logic clr;
        logic capture;
        logic scan;
        logic decide;
        logic lfix;
        logic ph1;
        logic ph2;
        logic pt1;
        logic pt2;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic scan_end;
        t_op  op;
    } t_sts;

endpackage

// File: sv/rlec_dp.sv
module rlec_dp
    import rlec_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_kind,
    input  logic [31:0] i_device,
    input  logic [31:0] i_entry_key,
    input  logic [7:0]  i_release_count,
    input  logic        i_unlinked,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [5:0]  o_slot,
    output logic [7:0]  o_refs_after,
    output logic        o_now_unused
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int LW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [LW-1:0] NIL  = LW'(TABLE_ENTRIES);
    localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

    t_entry        mem_e [TABLE_ENTRIES];
    logic [LW-1:0] mem_n [TABLE_ENTRIES];
    logic [LW-1:0] mem_p [TABLE_ENTRIES];

    logic [IW-1:0] r_clr;
    logic          r_kind;
    logic [31:0]   r_device;
    logic [31:0]   r_key;
    logic [7:0]    r_cnt;
    logic          r_unlinked;
    logic [LW-1:0] r_sa;
    logic          r_cv;
    logic [IW-1:0] r_ca;
    t_entry        r_ent_rd;
    logic          r_found;
    logic [IW-1:0] r_tgt;
    t_entry        r_tword;
    logic [LW-1:0] r_head;
    logic [LW-1:0] r_tail;
    logic [LW-1:0] r_nx_rd;
    logic [LW-1:0] r_pv_rd;
    logic          r_out_v;
    logic [2:0]    r_status;
    logic [5:0]    r_slot;
    logic [7:0]    r_refs;
    logic          r_unused;

    logic          issue;
    logic          match;
    logic [IW-1:0] tgt_c;
    logic [7:0]    rem;
    t_op           op;
    logic          e_we;
    logic [IW-1:0] e_wa;
    t_entry        e_wd;
    logic          n_we;
    logic [IW-1:0] n_wa;
    logic [LW-1:0] n_wd;
    logic          p_we;
    logic [IW-1:0] p_wa;
    logic [LW-1:0] p_wd;
    logic [LW-1:0] tgt_l;

    assign issue = (r_sa < NIL);
    assign tgt_c = r_found ? r_tgt : r_head[IW-1:0];
    assign tgt_l = LW'(r_tgt);
    assign rem   = r_tword.refs - r_cnt;

    always_comb begin
        if (r_kind == KIND_ACQUIRE) begin
            match = r_ent_rd.valid && (r_ent_rd.key == r_key) && (r_ent_rd.device == r_device);
        end else begin
            match = r_ent_rd.valid && (r_ent_rd.refs != 8'd0) && (r_ent_rd.key == r_key);
        end
    end

    always_comb begin
        if (r_kind == KIND_ACQUIRE) begin
            if (r_found) begin
                if (r_tword.refs == 8'hFF) op = OP_OVERFLOW;
                else if (r_tword.refs == 8'd0) op = OP_HIT_UNUSED;
                else op = OP_HIT;
            end else begin
                op = (r_head == NIL) ? OP_FULL : OP_LOAD;
            end
        end else begin
            if (!r_found) op = OP_NOT_FOUND;
            else if (r_cnt == 8'd0 || r_cnt > r_tword.refs) op = OP_BAD_COUNT;
            else if (rem != 8'd0) op = OP_REL_KEEP;
            else op = r_unlinked ? OP_REL_HEAD : OP_REL_TAIL;
        end
    end

    assign o_sts.clr_done = (r_clr == LAST);
    assign o_sts.scan_end = r_cv && (match || r_ca == LAST);
    assign o_sts.op       = op;

    always_comb begin
        e_we = 1'b0;
        e_wa = tgt_c;
        e_wd = r_tword;
        if (i_cmd.clr) begin
            e_we = 1'b1;
            e_wa = r_clr;
            e_wd = '0;
        end else if (i_cmd.decide) begin
            case (op)
                OP_HIT, OP_HIT_UNUSED: begin
                    e_we      = 1'b1;
                    e_wd.refs = r_tword.refs + 8'd1;
                end
                OP_LOAD: begin
                    e_we = 1'b1;
                    e_wd = '{valid: 1'b1, refs: 8'd1, device: r_device, key: r_key};
                end
                OP_REL_KEEP, OP_REL_TAIL: begin
                    e_we      = 1'b1;
                    e_wd.refs = rem;
                end
                OP_REL_HEAD: begin
                    e_we       = 1'b1;
                    e_wd.refs  = rem;
                    e_wd.valid = 1'b0;
                end
                default: e_we = 1'b0;
            endcase
        end
    end

    // Clear, unlink and push steps; each memory takes at most one write per cycle.
    always_comb begin
        n_we = 1'b0;
        n_wa = r_tgt;
        n_wd = NIL;
        p_we = 1'b0;
        p_wa = r_tgt;
        p_wd = NIL;
        if (i_cmd.clr) begin
            n_we = 1'b1;
            n_wa = r_clr;
            n_wd = (r_clr == '0) ? NIL : LW'(r_clr) - LW'(1);
            p_we = 1'b1;
            p_wa = r_clr;
            p_wd = (r_clr == LAST) ? NIL : LW'(r_clr) + LW'(1);
        end else if (i_cmd.lfix) begin
            n_we = (r_pv_rd != NIL);
            n_wa = r_pv_rd[IW-1:0];
            n_wd = r_nx_rd;
            p_we = (r_nx_rd != NIL);
            p_wa = r_nx_rd[IW-1:0];
            p_wd = r_pv_rd;
        end else if (i_cmd.ph1) begin
            p_we = (r_head != NIL);
            p_wa = r_head[IW-1:0];
            p_wd = tgt_l;
            n_we = 1'b1;
            n_wd = r_head;
        end else if (i_cmd.ph2) begin
            p_we = 1'b1;
        end else if (i_cmd.pt1) begin
            n_we = (r_tail != NIL);
            n_wa = r_tail[IW-1:0];
            n_wd = tgt_l;
            p_we = 1'b1;
            p_wd = r_tail;
        end else if (i_cmd.pt2) begin
            n_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_we) mem_e[e_wa] <= e_wd;
        if (n_we) mem_n[n_wa] <= n_wd;
        if (p_we) mem_p[p_wa] <= p_wd;
        if (issue) r_ent_rd <= mem_e[r_sa[IW-1:0]];
        r_nx_rd <= mem_n[tgt_c];
        r_pv_rd <= mem_p[tgt_c];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_sa    <= '0;
            r_cv    <= 1'b0;
            r_found <= 1'b0;
            r_head  <= LW'(LAST);
            r_tail  <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= i_cmd.decide;
            if (i_cmd.clr) r_clr <= r_clr + IW'(1);
            if (i_cmd.capture) begin
                r_sa    <= '0;
                r_cv    <= 1'b0;
                r_found <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cv <= issue;
                if (issue) r_sa <= r_sa + LW'(1);
                if (r_cv && match && !r_found) r_found <= 1'b1;
            end
            if (i_cmd.decide) r_found <= (op == OP_LOAD) ? 1'b1 : r_found;
            if (i_cmd.lfix) begin
                if (r_pv_rd == NIL) r_head <= r_nx_rd;
                if (r_nx_rd == NIL) r_tail <= r_pv_rd;
            end
            if (i_cmd.ph2) begin
                r_head <= tgt_l;
                if (r_head == NIL) r_tail <= tgt_l;
            end
            if (i_cmd.pt2) begin
                r_tail <= tgt_l;
                if (r_tail == NIL) r_head <= tgt_l;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind     <= i_kind;
            r_device   <= i_device;
            r_key      <= i_entry_key;
            r_cnt      <= i_release_count;
            r_unlinked <= i_unlinked;
        end
        if (i_cmd.scan && r_cv && match && !r_found) begin
            r_tgt   <= r_ca;
            r_tword <= r_ent_rd;
        end
        if (i_cmd.scan) r_ca <= r_sa[IW-1:0];
        if (i_cmd.decide) begin
            r_tgt    <= tgt_c;
            r_status <= STS_HIT;
            r_slot   <= 6'(tgt_c);
            r_refs   <= 8'd0;
            r_unused <= 1'b0;
            case (op)
                OP_HIT, OP_HIT_UNUSED: r_refs <= r_tword.refs + 8'd1;
                OP_LOAD: begin
                    r_status <= STS_LOADED;
                    r_refs   <= 8'd1;
                end
                OP_REL_KEEP: r_refs <= rem;
                OP_REL_HEAD, OP_REL_TAIL: r_unused <= 1'b1;
                OP_OVERFLOW: begin
                    r_status <= STS_OVERFLOW;
                    r_slot   <= '0;
                end
                OP_FULL: begin
                    r_status <= STS_FULL;
                    r_slot   <= '0;
                end
                OP_NOT_FOUND: begin
                    r_status <= STS_NOT_FOUND;
                    r_slot   <= '0;
                end
                default: begin
                    r_status <= STS_BAD_COUNT;
                    r_slot   <= '0;
                end
            endcase
        end
    end

    assign o_valid      = r_out_v;
    assign o_status     = r_status;
    assign o_slot       = r_slot;
    assign o_refs_after = r_refs;
    assign o_now_unused = r_unused;

endmodule

// File: sv/rlec_ctrl.sv
module rlec_ctrl
    import rlec_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_SCAN   = 9'b000000100,
        S_DECIDE = 9'b000001000,
        S_LFIX   = 9'b000010000,
        S_PH1    = 9'b000100000,
        S_PH2    = 9'b001000000,
        S_PT1    = 9'b010000000,
        S_PT2    = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (i_sts.clr_done) n_state = S_IDLE;
            S_IDLE:   if (start) n_state = S_SCAN;
            S_SCAN:   if (i_sts.scan_end) n_state = S_DECIDE;
            S_DECIDE: begin
                case (i_sts.op)
                    OP_HIT_UNUSED, OP_LOAD: n_state = S_LFIX;
                    OP_REL_HEAD:            n_state = S_PH1;
                    OP_REL_TAIL:            n_state = S_PT1;
                    default:                n_state = S_IDLE;
                endcase
            end
            S_PH1:    n_state = S_PH2;
            S_PT1:    n_state = S_PT2;
            S_LFIX, S_PH2, S_PT2: n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_cmd.clr     = (r_state == S_CLEAR);
    assign o_cmd.capture = (r_state == S_IDLE) && start;
    assign o_cmd.scan    = (r_state == S_SCAN);
    assign o_cmd.decide  = (r_state == S_DECIDE);
    assign o_cmd.lfix    = (r_state == S_LFIX);
    assign o_cmd.ph1     = (r_state == S_PH1);
    assign o_cmd.ph2     = (r_state == S_PH2);
    assign o_cmd.pt1     = (r_state == S_PT1);
    assign o_cmd.pt2     = (r_state == S_PT2);

endmodule

// File: sv/refcounted_lru_entry_cache_unit.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+------------------------------------------------
// command  | start && !busy      | i_kind, i_device, i_entry_key, i_release_count,
//          |                     | i_unlinked
// result   | o_valid, one cycle  | o_status, o_slot, o_refs_after, o_now_unused
//
// An item is captured, scanned and decided, then may update the list in LFIX,
// in PH1 and PH2 or in PT1 and PT2. The lookup scan reads one entry per cycle
// through the entry memory read port. After reset the memories are cleared with
// busy high. The unstallable result beat comes in the cycle after the decision.
module refcounted_lru_entry_cache_unit
    import rlec_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [31:0] i_device,
    input  logic [31:0] i_entry_key,
    input  logic [7:0]  i_release_count,
    input  logic        i_unlinked,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [5:0]  o_slot,
    output logic [7:0]  o_refs_after,
    output logic        o_now_unused
);

    t_cmd cmd;
    t_sts sts;

    rlec_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rlec_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_kind          (i_kind),
        .i_device        (i_device),
        .i_entry_key     (i_entry_key),
        .i_release_count (i_release_count),
        .i_unlinked      (i_unlinked),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_slot          (o_slot),
        .o_refs_after    (o_refs_after),
        .o_now_unused    (o_now_unused)
    );

endmodule

// File: sv/rlec_chk.sv
module rlec_chk
    import rlec_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [2:0]  o_status,
    input logic [5:0]  o_slot,
    input logic [7:0]  o_refs_after,
    input logic        o_now_unused
);

    // Every result beat closes an item that was being worked on.
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result beat without an item in progress");

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two result beats in a row");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STS_FULL || o_status == STS_NOT_FOUND
                    || o_status == STS_BAD_COUNT || o_status == STS_OVERFLOW)
        |-> (o_slot == 6'd0 && o_refs_after == 8'd0 && !o_now_unused))
        else $error("error result carries a slot or count");

    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_now_unused |-> (o_status == STS_HIT && o_refs_after == 8'd0))
        else $error("now_unused with nonzero count");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

endmodule

bind refcounted_lru_entry_cache_unit rlec_chk u_chk (.*);

// File: tb/sv/tb_top.sv
module tb_top;
    import rlec_pkg::*;

    localparam int NSLOTS    = 64;
    localparam int NIL       = NSLOTS;
    localparam int LIMIT_CYC = 1500000;

    typedef struct {
        logic        kind;
        logic [31:0] device;
        logic [31:0] key;
        logic [7:0]  cnt;
        logic        unlinked;
    } t_cmd_beat;

    typedef struct {
        logic [2:0] status;
        logic [5:0] slot;
        logic [7:0] refs;
        logic       now_unused;
    } t_res_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_kind;
    logic [31:0] i_device;
    logic [31:0] i_entry_key;
    logic [7:0]  i_release_count;
    logic        i_unlinked;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [5:0]  o_slot;
    logic [7:0]  o_refs_after;
    logic        o_now_unused;

    refcounted_lru_entry_cache_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_device       (i_device),
        .i_entry_key    (i_entry_key),
        .i_release_count(i_release_count),
        .i_unlinked     (i_unlinked),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_refs_after   (o_refs_after),
        .o_now_unused   (o_now_unused)
    );

    // Shadow copy of the cache table and its unused list.
    logic        tbl_valid [NSLOTS];
    logic [31:0] tbl_dev [NSLOTS];
    logic [31:0] tbl_key [NSLOTS];
    logic [7:0]  tbl_refs [NSLOTS];
    int          lru_next [NSLOTS];
    int          lru_prev [NSLOTS];
    int          lru_head;
    int          lru_tail;

    t_cmd_beat   pending_cmds[$];
    t_res_beat   expected_results[$];
    int          err_count;
    int          cycle_count;
    logic        stim_done;
    int          gap_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d expected %0d", what, got, want);
        err_count++;
    endtask

    function automatic void lru_unlink(input int s);
        int p;
        int n;
        p = lru_prev[s];
        n = lru_next[s];
        if (p == NIL) lru_head = n; else lru_next[p] = n;
        if (n == NIL) lru_tail = p; else lru_prev[n] = p;
        lru_next[s] = NIL;
        lru_prev[s] = NIL;
    endfunction

    function automatic void cache_reset();
        for (int i = 0; i < NSLOTS; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_dev[i] = '0;
            tbl_key[i] = '0;
            tbl_refs[i] = '0;
            lru_next[i] = (i == 0) ? NIL : i - 1;
            lru_prev[i] = (i + 1 >= NSLOTS) ? NIL : i + 1;
        end
        lru_head = NSLOTS - 1;
        lru_tail = 0;
    endfunction

    function automatic t_res_beat cache_predict(input t_cmd_beat c);
        t_res_beat r;
        int        hit;
        int        s;
        r = '{STS_HIT, 6'd0, 8'd0, 1'b0};
        hit = NIL;
        if (c.kind == KIND_ACQUIRE) begin
            for (int i = 0; i < NSLOTS; i++)
                if (hit == NIL && tbl_valid[i] && tbl_key[i] == c.key && tbl_dev[i] == c.device)
                    hit = i;
            if (hit != NIL) begin
                if (tbl_refs[hit] == 8'hFF) begin
                    r.status = STS_OVERFLOW;
                end else begin
                    if (tbl_refs[hit] == 0) lru_unlink(hit);
                    tbl_refs[hit]++;
                    r.slot = hit[5:0];
                    r.refs = tbl_refs[hit];
                end
            end else if (lru_head == NIL) begin
                r.status = STS_FULL;
            end else begin
                s = lru_head;
                lru_unlink(s);
                tbl_valid[s] = 1'b1;
                tbl_dev[s] = c.device;
                tbl_key[s] = c.key;
                tbl_refs[s] = 8'd1;
                r.status = STS_LOADED;
                r.slot = s[5:0];
                r.refs = 8'd1;
            end
        end else begin
            for (int i = 0; i < NSLOTS; i++)
                if (hit == NIL && tbl_valid[i] && tbl_refs[i] != 0 && tbl_key[i] == c.key)
                    hit = i;
            if (hit == NIL) begin
                r.status = STS_NOT_FOUND;
            end else if (c.cnt == 0 || c.cnt > tbl_refs[hit]) begin
                r.status = STS_BAD_COUNT;
            end else begin
                tbl_refs[hit] = tbl_refs[hit] - c.cnt;
                r.slot = hit[5:0];
                r.refs = tbl_refs[hit];
                if (tbl_refs[hit] == 0) begin
                    r.now_unused = 1'b1;
                    if (c.unlinked) begin
                        tbl_valid[hit] = 1'b0;
                        lru_prev[hit] = NIL;
                        lru_next[hit] = lru_head;
                        if (lru_head == NIL) lru_tail = hit; else lru_prev[lru_head] = hit;
                        lru_head = hit;
                    end else begin
                        lru_next[hit] = NIL;
                        lru_prev[hit] = lru_tail;
                        if (lru_tail == NIL) lru_head = hit; else lru_next[lru_tail] = hit;
                        lru_tail = hit;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    function automatic t_cmd_beat mk(input logic k, input logic [31:0] d, input logic [31:0] e,
                                     input logic [7:0] n, input logic u);
        t_cmd_beat c;
        c.kind = k;
        c.device = d;
        c.key = e;
        c.cnt = n;
        c.unlinked = u;
        return c;
    endfunction

    // Keys are mostly drawn from a small pool so that hits, shared keys and a full table occur.
    initial begin
        int          phase;
        logic [31:0] dv;
        logic [31:0] ky;
        stim_done = 1'b0;
        // Directed: loads at field extremes, hit, full table and release corners.
        pending_cmds.push_back(mk(KIND_RELEASE, '1, 32'd5, 8'd1, 1'b0));
        pending_cmds.push_back(mk(KIND_ACQUIRE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1));
        pending_cmds.push_back(mk(KIND_ACQUIRE, 32'h0, 32'h0, 8'h0, 1'b0));
        pending_cmds.push_back(mk(KIND_ACQUIRE, 32'h0, 32'h0, 8'h0, 1'b0));
        pending_cmds.push_back(mk(KIND_ACQUIRE, 32'h1, 32'h0, 8'h0, 1'b0));
        pending_cmds.push_back(mk(KIND_RELEASE, 32'h0, 32'h0, 8'd0, 1'b0));
        pending_cmds.push_back(mk(KIND_RELEASE, 32'h0, 32'h0, 8'd3, 1'b0));
        pending_cmds.push_back(mk(KIND_RELEASE, 32'h0, 32'h0, 8'd2, 1'b1));
        pending_cmds.push_back(mk(KIND_RELEASE, 32'h0, 32'h0, 8'd1, 1'b0));
        pending_cmds.push_back(mk(KIND_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1, 1'b0));
        pending_cmds.push_back(mk(KIND_ACQUIRE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 1'b0));
        // Drive one slot up to 255 references, then release them all at once.
        for (int i = 0; i < 255; i++)
            pending_cmds.push_back(mk(KIND_ACQUIRE, 32'hA5A5_5A5A, 32'h1234_5678, 8'd0, 1'b0));
        pending_cmds.push_back(mk(KIND_RELEASE, 32'h0, 32'h1234_5678, 8'd255, 1'b1));
        // Acquire one more key than there are slots, so the table fills and reports full, then drain.
        for (int i = 0; i < NSLOTS + 1; i++)
            pending_cmds.push_back(mk(KIND_ACQUIRE, 32'h77, 32'h1000 + i, 8'd0, 1'b0));
        for (int i = 0; i < NSLOTS; i++)
            pending_cmds.push_back(mk(KIND_RELEASE, 32'h0, 32'h1000 + i, 8'd1, i[0]));
        for (int n = 0; n < 1450; n++) begin
            phase = $urandom_range(0, 99);
            dv = (phase < 85) ? {$urandom_range(0, 3)} : $urandom();
            ky = (phase < 85) ? {$urandom_range(0, 40)} : $urandom();
            if (n % 400 > 300 && $urandom_range(0, 1)) ky = 32'd100 + (n % 70);
            pending_cmds.push_back(mk($urandom_range(0, 99) < 50, dv, ky,
                ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3)),
                $urandom_range(0, 1)));
        end
        stim_done = 1'b1;
    end

    // Driver: a new beat is only presented while the block is idle, so it is taken at
    // the next rising edge; start stays high while the block works on it.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= 0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (pending_cmds.size() != 0 && !busy) begin
            t_cmd_beat c;
            c = pending_cmds.pop_front();
            expected_results.push_back(cache_predict(c));
            start <= 1'b1;
            i_kind <= c.kind;
            i_device <= c.device;
            i_entry_key <= c.key;
            i_release_count <= c.cnt;
            i_unlinked <= c.unlinked;
            gap_left <= pick_gap();
        end else begin
            start <= 1'b0;
        end
    end

    // Each result beat is compared against the oldest outstanding prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                t_res_beat w;
                w = expected_results.pop_front();
                if (o_status !== w.status) report_mismatch("status", o_status, w.status);
                if (o_slot !== w.slot) report_mismatch("slot", o_slot, w.slot);
                if (o_refs_after !== w.refs) report_mismatch("refs_after", o_refs_after, w.refs);
                if (o_now_unused !== w.now_unused)
                    report_mismatch("now_unused", o_now_unused, w.now_unused);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYC) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        err_count = 0;
        cycle_count = 0;
        cache_reset();
        start = 1'b0;
        gap_left = 0;
        i_kind = 1'b0;
        i_device = '0;
        i_entry_key = '0;
        i_release_count = '0;
        i_unlinked = 1'b0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (stim_done && pending_cmds.size() == 0 && expected_results.size() == 0);
        repeat (100) @(posedge i_clk);
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: files.f
sv/rlec_pkg.sv
sv/rlec_dp.sv
sv/rlec_ctrl.sv
sv/refcounted_lru_entry_cache_unit.sv
sv/rlec_chk.sv
tb/sv/tb_top.sv
